/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/lkvc_pkg.sv */
// ---------------------------------------------------------------------------
// lkvc_pkg
// Types and constants shared by the LRU key/value cache.
// ---------------------------------------------------------------------------
package lkvc_pkg;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} rsp_t;

	// broadcast to every entry for the request being processed
	typedef struct packed {
		logic               go;
		logic               put;
		logic               any_hit;
		logic               evict;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} entry_cmd_t;

	typedef struct packed {
		logic valid;
		logic match;
		logic victim;
	} entry_sts_t;

endpackage

/* rtl/core/lru_key_value_cache.sv */
// ---------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Takes one get or put request per clock while req_stall is low. A request
// is registered on acceptance and resolved, once the response register is
// free, against all ENTRIES entries at once (parallel key compare, rank
// update, victim and free-slot pick); its response is then held in the
// response register, and the sustained rate is one request per cycle
// while the receiver does not stall. Ranks stay a dense
// permutation of 0..count-1, so the eviction victim is the valid entry
// whose rank equals count-1. The capacity setting is taken as 1 when 0 and
// clamped to ENTRIES; write it only while the cache is idle.
`include "assert_macros.svh"

module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  lkvc_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output lkvc_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkvc_pkg::CFG_W-1:0]    cfg_data
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;

	logic                        s1_valid_q;
	lkvc_pkg::req_t              req_s1;
	logic [lkvc_pkg::CFG_W-1:0]  cap_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        rsp_valid_q;
	lkvc_pkg::rsp_t              rsp_q;

	logic                        out_free;
	logic                        proc;
	logic                        is_put;
	logic                        any_hit;
	logic                        miss_put;
	logic                        full;
	logic                        evict;
	logic [CMP_W-1:0]            eff_cap;
	logic [CNT_W-1:0]            cnt_dec;
	logic [RANK_W-1:0]           last_rank;
	logic [RANK_W-1:0]           hit_rank;
	logic signed [31:0]          hit_value;

	lkvc_pkg::entry_cmd_t        cmd;
	lkvc_pkg::entry_sts_t        sts [ENTRIES];
	logic [RANK_W-1:0]           rank_hit [ENTRIES];
	logic signed [31:0]          value_hit [ENTRIES];
	logic [ENTRIES-1:0]          valid_vec;
	logic [ENTRIES-1:0]          match_vec;
	logic [ENTRIES-1:0]          victim_vec;
	logic [ENTRIES-1:0]          free_vec;
	logic [ENTRIES-1:0]          fill_vec;

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign proc      = s1_valid_q && out_free;
	assign req_stall = s1_valid_q && !out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!req_stall) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// lookup
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_vec[i]  = sts[i].valid;
			match_vec[i]  = sts[i].match;
			victim_vec[i] = sts[i].victim;
		end
	end

	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_rank  = hit_rank | rank_hit[i];
			hit_value = hit_value | value_hit[i];
		end
	end

	assign is_put  = (req_s1.action == lkvc_pkg::ACT_PUT);
	assign any_hit = |match_vec;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign full      = CMP_W'(cnt_q) >= eff_cap;
	assign miss_put  = is_put && !any_hit;
	assign evict     = miss_put && full;
	assign cnt_dec   = cnt_q - CNT_W'(1);
	assign last_rank = cnt_dec[RANK_W-1:0];

	// lowest free slot, counting the victim as free
	assign free_vec = ~valid_vec | (evict ? victim_vec : '0);
	assign fill_vec = (proc && miss_put) ? (free_vec & (~free_vec + ENTRIES'(1))) : '0;

	assign cmd.go      = proc;
	assign cmd.put     = is_put;
	assign cmd.any_hit = any_hit;
	assign cmd.evict   = evict;
	assign cmd.key     = req_s1.key;
	assign cmd.value   = req_s1.value;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
		lkvc_entry #(
			.RANK_W(RANK_W)
		) u_entry (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.fill      (fill_vec[g]),
			.hit_rank  (hit_rank),
			.last_rank (last_rank),
			.sts       (sts[g]),
			.rank_hit  (rank_hit[g]),
			.value_hit (value_hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (proc && miss_put && !evict) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= proc;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			rsp_q.hit        <= any_hit;
			rsp_q.read_value <= (!is_put && any_hit) ? hit_value : '0;
			rsp_q.evicted    <= evict;
		end
	end

	`ASSERT_IMPL(a_cnt_matches_valid, clk, arst_n, 1'b1, $countones(valid_vec) == cnt_q)
	`ASSERT_IMPL(a_single_match, clk, arst_n, s1_valid_q, $onehot0(match_vec))
	`ASSERT_IMPL(a_victim_unique, clk, arst_n, proc && evict, $onehot(victim_vec))
	`ASSERT_NEXT(a_evict_reported, clk, arst_n, proc && evict, rsp_valid_q && rsp_q.evicted)

endmodule

/* rtl/core/lkvc_entry.sv */
// ---------------------------------------------------------------------------
// lkvc_entry
// One cache entry: key/value storage, valid bit, recency rank and compare.
// ---------------------------------------------------------------------------
module lkvc_entry #(
	parameter int RANK_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkvc_pkg::entry_cmd_t    cmd,
	input  logic                    fill,
	input  logic [RANK_W-1:0]       hit_rank,
	input  logic [RANK_W-1:0]       last_rank,
	output lkvc_pkg::entry_sts_t    sts,
	output logic [RANK_W-1:0]       rank_hit,
	output logic signed [31:0]      value_hit
);

	logic                valid_q;
	logic [RANK_W-1:0]   rank_q;
	logic signed [31:0]  key_q;
	logic signed [31:0]  value_q;
	logic                match;
	logic                victim;

	assign match  = valid_q && (key_q == cmd.key);
	assign victim = valid_q && (rank_q == last_rank);

	assign sts.valid  = valid_q;
	assign sts.match  = match;
	assign sts.victim = victim;

	assign rank_hit  = match ? rank_q : '0;
	assign value_hit = match ? value_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (cmd.go) begin
			if (cmd.any_hit) begin
				if (match) begin
					rank_q <= '0;
				end else if (valid_q && (rank_q < hit_rank)) begin
					rank_q <= rank_q + 1'b1;
				end
			end else if (cmd.put) begin
				if (fill) begin
					valid_q <= 1'b1;
					rank_q  <= '0;
				end else if (cmd.evict && victim) begin
					valid_q <= 1'b0;
					rank_q  <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && fill) begin
			key_q   <= cmd.key;
			value_q <= cmd.value;
		end else if (cmd.go && cmd.any_hit && cmd.put && match) begin
			value_q <= cmd.value;
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache testbench
// Streams get/put requests through the cache under changing capacity settings
// and sender/receiver idling, and checks every response against an LRU
// predictor that tracks entries, recency ranks and the entry count.
// ----------------------------------------------------------------------------
module testbench;

	localparam int ENTRIES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lkvc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lkvc_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lkvc_pkg::CFG_W-1:0] cfg_data = '0;

	lkvc_pkg::req_t req_backlog [$];
	lkvc_pkg::rsp_t lookup_results [$];
	int mismatches = 0;
	int send_idle_pct = 22;
	int rcv_stall_pct = 80;

	// predictor state
	bit line_valid [ENTRIES];
	logic [31:0] line_key [ENTRIES];
	logic [31:0] line_data [ENTRIES];
	int line_rank [ENTRIES];
	int line_count = 0;
	logic [lkvc_pkg::CFG_W-1:0] cap_setting = lkvc_pkg::CAP_RESET;

	lru_key_value_cache #(.ENTRIES(ENTRIES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lkvc_pkg::rsp_t cache_access(lkvc_pkg::req_t r);
		lkvc_pkg::rsp_t res;
		int slot;
		int victim;
		int old_rank;
		int eff_cap;
		res = '0;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && line_valid[i] && line_key[i] == r.key)
				slot = i;
		res.hit = (slot >= 0);
		if (slot >= 0) begin
			if (r.action == lkvc_pkg::ACT_GET)
				res.read_value = line_data[slot];
			else
				line_data[slot] = r.value;
			old_rank = line_rank[slot];
			for (int i = 0; i < ENTRIES; i++)
				if (line_valid[i] && line_rank[i] < old_rank)
					line_rank[i]++;
			line_rank[slot] = 0;
		end else if (r.action == lkvc_pkg::ACT_PUT) begin
			eff_cap = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
			if (line_count >= eff_cap) begin
				victim = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					line_valid[victim] = 1'b0;
					line_rank[victim] = 0;
					if (line_count > 0)
						line_count--;
				end
				res.evicted = 1'b1;
			end
			for (int i = 0; i < ENTRIES; i++)
				if (slot < 0 && !line_valid[i])
					slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (line_valid[i])
						line_rank[i]++;
				line_valid[slot] = 1'b1;
				line_key[slot] = r.key;
				line_data[slot] = r.value;
				line_rank[slot] = 0;
				line_count++;
			end
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				lookup_results.push_back(cache_access(req));
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin : mon
		lkvc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (lookup_results.size() == 0) begin
					$display("%0t response with no request outstanding: %h", $time, rsp);
					mismatches++;
				end else begin
					want = lookup_results.pop_front();
					if (rsp.hit !== want.hit) begin
						$display("%0t hit: expected %0b actual %0b", $time, want.hit, rsp.hit);
						mismatches++;
					end
					if (rsp.read_value !== want.read_value) begin
						$display("%0t read_value: expected %h actual %h", $time,
							want.read_value, rsp.read_value);
						mismatches++;
					end
					if (rsp.evicted !== want.evicted) begin
						$display("%0t evicted: expected %0b actual %0b", $time,
							want.evicted, rsp.evicted);
						mismatches++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	task automatic add_req(logic act, logic [31:0] k, logic [31:0] v);
		lkvc_pkg::req_t r;
		r.action = act;
		r.key = k;
		r.value = v;
		req_backlog.push_back(r);
	endtask

	task automatic queue_random(int n, int pool_n);
		logic [31:0] pool [$];
		lkvc_pkg::req_t r;
		for (int i = 0; i < pool_n; i++)
			pool.push_back($urandom);
		repeat (n) begin
			r.action = ($urandom_range(1) != 0);
			r.key = ($urandom_range(99) < 85) ? pool[$urandom_range(pool.size() - 1)] : $urandom;
			r.value = $urandom;
			req_backlog.push_back(r);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req_valid || lookup_results.size() != 0);
	endtask

	task automatic write_capacity(logic [lkvc_pkg::CFG_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = v;
	endtask

	initial begin
		logic [lkvc_pkg::CFG_W-1:0] cap_plan [9];
		int eff_cap;
		cap_plan = '{5'd0, 5'd2, 5'd5, 5'd31, 5'd9, 5'd16, 5'd1, 5'd5, 5'd16};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cache and extremes at reset capacity, then update in place and eviction at capacity 3
		add_req(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
		add_req(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		add_req(lkvc_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		add_req(lkvc_pkg::ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		add_req(lkvc_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
		wait_idle();
		write_capacity(5'd3);
		add_req(lkvc_pkg::ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
		add_req(lkvc_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		add_req(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
		add_req(lkvc_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		add_req(lkvc_pkg::ACT_GET, 32'h0000_0005, 32'hFFFF_FFFF);
		add_req(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h0000_0000);
		add_req(lkvc_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h1234_5678);
		add_req(lkvc_pkg::ACT_PUT, 32'h0000_0000, 32'h8000_0000);
		add_req(lkvc_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);

		for (int p = 0; p < 9; p++) begin
			wait_idle();
			if (p == 3) begin
				send_idle_pct = 80;
				rcv_stall_pct = 22;
			end else if (p == 6) begin
				send_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			write_capacity(cap_plan[p]);
			eff_cap = (cap_plan[p] == 0) ? 1 : (cap_plan[p] > ENTRIES) ? ENTRIES : cap_plan[p];
			queue_random(139, eff_cap + $urandom_range(1, 4));
		end

		wait_idle();
		repeat (3) @(posedge clk);
		if (lookup_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
